// ===== design/wsd_pkg.sv =====
package wsd_pkg;

	// parse phases
	localparam logic [2:0] PH_FIRST   = 3'd0;
	localparam logic [2:0] PH_SECOND  = 3'd1;
	localparam logic [2:0] PH_EXT     = 3'd2;
	localparam logic [2:0] PH_KEY     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	localparam logic       KIND_HEADER  = 1'b0;
	localparam logic       KIND_PAYLOAD = 1'b1;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [2:0] KEY_BYTES   = 3'd4;

	typedef struct packed {
		logic        kind;
		logic        fin;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] frame_len;
		logic [7:0]  data_byte;
		logic        last;
	} res_t;

endpackage

// ===== design/wsd_parse.sv =====
// Header/payload parser: state update and result for one byte.
module wsd_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	output logic              res_valid,
	output wsd_pkg::res_t     res
);

	logic [2:0]  phase_q,     phase_d;
	logic        fin_q,       fin_d;
	logic [3:0]  opcode_q,    opcode_d;
	logic        masked_q,    masked_d;
	logic [63:0] flen_q,      flen_d;
	logic [3:0]  ext_left_q,  ext_left_d;
	logic [31:0] key_q,       key_d;
	logic [2:0]  key_left_q,  key_left_d;
	logic [63:0] pay_left_q,  pay_left_d;
	logic [1:0]  key_idx_q,   key_idx_d;

	logic [6:0]  len7;
	logic [7:0]  kb;
	logic        hdr;   // header completes with this byte
	logic        len_done;

	always_comb begin
		phase_d    = phase_q;
		fin_d      = fin_q;
		opcode_d   = opcode_q;
		masked_d   = masked_q;
		flen_d     = flen_q;
		ext_left_d = ext_left_q;
		key_d      = key_q;
		key_left_d = key_left_q;
		pay_left_d = pay_left_q;
		key_idx_d  = key_idx_q;
		len7       = rx_byte[6:0];
		kb         = 8'd0;
		hdr        = 1'b0;
		len_done   = 1'b0;
		res_valid  = 1'b0;
		res        = '0;

		case (phase_q)
			wsd_pkg::PH_SECOND: begin
				masked_d = rx_byte[7];
				if (len7 inside {wsd_pkg::LEN7_EXT16, wsd_pkg::LEN7_EXT64}) begin
					flen_d     = 64'd0;
					ext_left_d = (len7 == wsd_pkg::LEN7_EXT16) ?
						wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES;
					phase_d    = wsd_pkg::PH_EXT;
				end else begin
					flen_d   = {57'd0, len7};
					len_done = 1'b1;
				end
			end
			wsd_pkg::PH_EXT: begin
				flen_d     = {flen_q[55:0], rx_byte};
				ext_left_d = ext_left_q - 4'd1;
				len_done   = (ext_left_q == 4'd1);
			end
			wsd_pkg::PH_KEY: begin
				key_d      = {key_q[23:0], rx_byte};
				key_left_d = key_left_q - 3'd1;
				hdr        = (key_left_q == 3'd1);
			end
			wsd_pkg::PH_PAYLOAD: begin
				if (masked_q) begin
					case (key_idx_q)
						2'd0:    kb = key_q[31:24];
						2'd1:    kb = key_q[23:16];
						2'd2:    kb = key_q[15:8];
						default: kb = key_q[7:0];
					endcase
				end
				key_idx_d  = key_idx_q + 2'd1;
				pay_left_d = pay_left_q - 64'd1;
				if (pay_left_q == 64'd1)
					phase_d = wsd_pkg::PH_FIRST;
				res_valid     = 1'b1;
				res.kind      = wsd_pkg::KIND_PAYLOAD;
				res.fin       = fin_q;
				res.opcode    = opcode_q;
				res.masked    = masked_q;
				res.frame_len = flen_q;
				res.data_byte = rx_byte ^ kb;
				res.last      = (pay_left_q == 64'd1);
			end
			default: begin
				// first header byte; spare phase codes land here too
				fin_d    = rx_byte[7];
				opcode_d = rx_byte[3:0];
				phase_d  = wsd_pkg::PH_SECOND;
			end
		endcase

		if (len_done) begin
			if (masked_d) begin
				key_d      = 32'd0;
				key_left_d = wsd_pkg::KEY_BYTES;
				phase_d    = wsd_pkg::PH_KEY;
			end else begin
				hdr = 1'b1;
			end
		end

		if (hdr) begin
			pay_left_d    = flen_d;
			key_idx_d     = 2'd0;
			phase_d       = (flen_d == 64'd0) ? wsd_pkg::PH_FIRST : wsd_pkg::PH_PAYLOAD;
			res_valid     = 1'b1;
			res.kind      = wsd_pkg::KIND_HEADER;
			res.fin       = fin_d;
			res.opcode    = opcode_d;
			res.masked    = masked_d;
			res.frame_len = flen_d;
			res.data_byte = 8'd0;
			res.last      = (flen_d == 64'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wsd_pkg::PH_FIRST;
			fin_q      <= 1'b0;
			opcode_q   <= 4'd0;
			masked_q   <= 1'b0;
			flen_q     <= 64'd0;
			ext_left_q <= 4'd0;
			key_q      <= 32'd0;
			key_left_q <= 3'd0;
			pay_left_q <= 64'd0;
			key_idx_q  <= 2'd0;
		end else if (step) begin
			phase_q    <= phase_d;
			fin_q      <= fin_d;
			opcode_q   <= opcode_d;
			masked_q   <= masked_d;
			flen_q     <= flen_d;
			ext_left_q <= ext_left_d;
			key_q      <= key_d;
			key_left_q <= key_left_d;
			pay_left_q <= pay_left_d;
			key_idx_q  <= key_idx_d;
		end
	end

endmodule

// ===== design/wsd_out_buf.sv =====
// Result register with one skid entry behind it.
module wsd_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wsd_pkg::res_t     push_res,
	output logic              can_push,
	output logic              out_valid,
	input  logic              out_ready,
	output wsd_pkg::res_t     out_res
);

	logic          main_vld_q;
	wsd_pkg::res_t main_q;
	logic          skid_vld_q;
	wsd_pkg::res_t skid_q;
	logic          load_main;

	assign can_push  = !skid_vld_q;
	assign out_valid = main_vld_q;
	assign out_res   = main_q;
	assign load_main = !main_vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (load_main) begin
			if (skid_vld_q) begin
				main_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				main_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_main) begin
			if (skid_vld_q)
				main_q <= skid_q;
			else if (push)
				main_q <= push_res;
		end else if (push) begin
			skid_q <= push_res;
		end
	end

endmodule

// ===== design/websocket_frame_deframer.sv =====
// WebSocket frame deframer.
// Input channel (in_valid/in_ready, rx_byte): the received stream, one byte
// per request. Output channel (out_valid/out_ready): one result request per
// completed header (kind=0, data_byte=0) and one per payload byte (kind=1,
// unmasked with key byte index mod 4). fin, opcode, masked and
// frame_len repeat the current frame's values on every result; last
// marks the final payload byte, or the header itself when the length is 0.
// Bytes that only build up the header (first byte, length, extended
// length, masking key) produce no result.
// A result is registered in the result register, or in the skid entry while
// a result waits. Throughput: one byte per cycle while in_ready is high, with
// a combinational parser step (64-bit length decrement and compare) feeding the result register.
// A skid entry behind the result register keeps in_ready high for one
// further request while a result waits; in_ready falls only when both are
// full, and rises again as soon as out_ready drains one.
// Reset (arst_n low) clears all parse state and both output entries; the
// block then waits for the first header byte of a new frame.
module websocket_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic        fin,
	output logic [3:0]  opcode,
	output logic        masked,
	output logic [63:0] frame_len,
	output logic [7:0]  data_byte,
	output logic        last
);

	logic          step;
	logic          res_valid;
	wsd_pkg::res_t res;
	wsd_pkg::res_t out_res;

	// a byte is taken whenever the skid entry is free
	assign step = in_valid && in_ready;

	wsd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (rx_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	wsd_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step && res_valid),
		.push_res  (res),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign kind      = out_res.kind;
	assign fin       = out_res.fin;
	assign opcode    = out_res.opcode;
	assign masked    = out_res.masked;
	assign frame_len = out_res.frame_len;
	assign data_byte = out_res.data_byte;
	assign last      = out_res.last;

endmodule

// ===== design/wsd_checker.sv =====
module wsd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_ready,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        kind,
	input  logic [63:0] frame_len,
	input  logic [7:0]  data_byte,
	input  logic        last
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte)
			&& $stable(frame_len) && $stable(last))
		else $error("stalled result changed");

	// empty frame header closes the frame
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == wsd_pkg::KIND_HEADER && frame_len == 64'd0 |-> last)
		else $error("empty header not last");

	a_hdr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == wsd_pkg::KIND_HEADER && frame_len != 64'd0 |-> !last)
		else $error("header with payload marked last");

	a_hdr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == wsd_pkg::KIND_HEADER |-> data_byte == 8'd0)
		else $error("header carries data");

	// back-pressure only with a result pending
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.frame_len (frame_len),
	.data_byte (data_byte),
	.last      (last)
);
